/* src/frdo_pkg.sv */
// frdo_pkg: sizes, codes and shared types of the frame ring with drop-oldest.
// No dependencies; every other file of the block but frdo_ram refers to it by scoped name.
`default_nettype none
package frdo_pkg;

	localparam int SLOTS      = 64;
	localparam int SLOT_BYTES = 2048;
	localparam int MIN_FRAME  = 14;

	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int OFF_W   = $clog2(SLOT_BYTES);
	localparam int LEN_W   = $clog2(SLOT_BYTES + 1);
	localparam int STORE_DEPTH = SLOTS * SLOT_BYTES;
	localparam int ADDR_W  = $clog2(STORE_DEPTH);

	localparam int DATA_W      = 8;
	localparam int MAX_LEN_W   = 12;
	localparam int FRAME_LEN_W = 12;
	localparam int DROP_W      = 32;

	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_FETCH = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_BYTE     = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_TOO_LONG = 2'd2
	} stat_t;

	typedef struct packed {
		op_t                  op;
		logic [DATA_W-1:0]    data;
		logic                 last;
		logic [MAX_LEN_W-1:0] max_len;
	} q_entry_t;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		next_slot = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

	function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
		slot_base = ADDR_W'(s) * ADDR_W'(SLOT_BYTES);
	endfunction

endpackage
`default_nettype wire

/* src/frdo_req_if.sv */
// frdo_req_if: request channel, one write or fetch word per handshake.
// Depends on frdo_pkg for field widths.
`default_nettype none
interface frdo_req_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [frdo_pkg::DATA_W-1:0]    data;
	logic                           last;
	logic [frdo_pkg::MAX_LEN_W-1:0] max_len;

	modport source (output valid, kind, data, last, max_len, input ready);
	modport sink   (input valid, kind, data, last, max_len, output ready);
endinterface
`default_nettype wire

/* src/frdo_rsp_if.sv */
// frdo_rsp_if: response channel, one fetch result word per handshake.
// Depends on frdo_pkg for field widths.
`default_nettype none
interface frdo_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       status;
	logic [frdo_pkg::DATA_W-1:0]      byte_out;
	logic [frdo_pkg::FRAME_LEN_W-1:0] frame_len;
	logic                             first;
	logic                             final_res;
	logic [frdo_pkg::DROP_W-1:0]      drop_count;

	modport source (output valid, status, byte_out, frame_len, first, final_res, drop_count,
		input ready);
	modport sink   (input valid, status, byte_out, frame_len, first, final_res, drop_count,
		output ready);
endinterface
`default_nettype wire

/* src/frdo_ram.sv */
// frdo_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module frdo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

/* src/frdo_front.sv */
// frdo_front: accepts request words, tags them write or fetch, and queues them.
// Depends on frdo_pkg and frdo_req_if.
`default_nettype none
module frdo_front (
	input  wire logic       clk,
	input  wire logic       arst_n,
	frdo_req_if.sink        req,
	output frdo_pkg::q_entry_t q_item,
	output logic            q_valid,
	input  wire logic       q_pop
);
	frdo_pkg::q_entry_t              ent_q [frdo_pkg::Q_DEPTH];
	logic [frdo_pkg::QPTR_W-1:0]     wptr_q;
	logic [frdo_pkg::QPTR_W-1:0]     rptr_q;
	logic [frdo_pkg::QCNT_W-1:0]     cnt_q;
	frdo_pkg::q_entry_t              in_item;
	logic                            push;
	logic                            pop;

	function automatic logic [frdo_pkg::QPTR_W-1:0] qnext(input logic [frdo_pkg::QPTR_W-1:0] p);
		qnext = (p == frdo_pkg::QPTR_W'(frdo_pkg::Q_DEPTH - 1)) ? '0
			: p + frdo_pkg::QPTR_W'(1);
	endfunction

	always_comb begin
		in_item.op      = req.kind ? frdo_pkg::OP_FETCH : frdo_pkg::OP_WRITE;
		in_item.data    = req.data;
		in_item.last    = req.last;
		in_item.max_len = req.max_len;
	end

	assign req.ready = (cnt_q != frdo_pkg::QCNT_W'(frdo_pkg::Q_DEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_item    = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= qnext(wptr_q);
			end
			if (pop) begin
				rptr_q <= qnext(rptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + frdo_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - frdo_pkg::QCNT_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

/* src/frdo_back.sv */
// frdo_back: executes queued words against the slot ring and frame store.
// Depends on frdo_pkg, frdo_ram and frdo_rsp_if.
`default_nettype none
module frdo_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire frdo_pkg::q_entry_t q_item,
	input  wire logic          q_valid,
	output logic               q_pop,
	frdo_rsp_if.source         rsp
);
	typedef enum logic [1:0] {
		PH_ISSUE = 2'b01,
		PH_DONE  = 2'b10
	} phase_t;

	phase_t                           phase_q;
	logic [frdo_pkg::SLOT_W-1:0]      head_q;
	logic [frdo_pkg::SLOT_W-1:0]      tail_q;
	logic [frdo_pkg::LEN_W-1:0]       wcnt_q;
	logic                             wover_q;
	logic [frdo_pkg::OFF_W-1:0]       roff_q;
	logic [frdo_pkg::DROP_W-1:0]      drops_q;
	logic                             empty_s1;
	logic [frdo_pkg::MAX_LEN_W-1:0]   maxlen_s1;

	logic                             ovalid_q;
	frdo_pkg::stat_t                  status_q;
	logic [frdo_pkg::DATA_W-1:0]      byte_q;
	logic [frdo_pkg::FRAME_LEN_W-1:0] flen_q;
	logic                             first_q;
	logic                             fin_q;
	logic [frdo_pkg::DROP_W-1:0]      dropc_q;

	logic                             take;
	logic                             is_wr;
	logic                             is_fe;
	logic                             room;
	logic [frdo_pkg::LEN_W-1:0]       cnt_after;
	logic                             over_after;
	logic                             commit;
	logic [frdo_pkg::SLOT_W-1:0]      head_nxt;
	logic                             ring_full;
	logic                             st_we;
	logic [frdo_pkg::ADDR_W-1:0]      st_waddr;
	logic [frdo_pkg::ADDR_W-1:0]      st_raddr;
	logic [frdo_pkg::DATA_W-1:0]      st_rdata;
	logic [frdo_pkg::LEN_W-1:0]       len_rdata;
	logic                             done;

	frdo_pkg::stat_t                  res_status;
	logic [frdo_pkg::DATA_W-1:0]      res_byte;
	logic [frdo_pkg::FRAME_LEN_W-1:0] res_flen;
	logic                             res_first;
	logic                             res_fin;
	logic                             adv_tail;
	logic                             roff_clr;
	logic                             roff_inc;

	assign take  = (phase_q == PH_ISSUE) && q_valid;
	assign q_pop = take;
	assign is_wr = take && (q_item.op == frdo_pkg::OP_WRITE);
	assign is_fe = take && (q_item.op == frdo_pkg::OP_FETCH);

	assign room       = (wcnt_q < frdo_pkg::LEN_W'(frdo_pkg::SLOT_BYTES));
	assign cnt_after  = room ? wcnt_q + frdo_pkg::LEN_W'(1) : wcnt_q;
	assign over_after = wover_q || !room;
	assign commit     = is_wr && q_item.last && !over_after
		&& (cnt_after >= frdo_pkg::LEN_W'(frdo_pkg::MIN_FRAME));
	assign head_nxt   = frdo_pkg::next_slot(head_q);
	assign ring_full  = (head_nxt == tail_q);

	assign st_we    = is_wr && room;
	assign st_waddr = frdo_pkg::slot_base(head_q)
		+ frdo_pkg::ADDR_W'(wcnt_q[frdo_pkg::OFF_W-1:0]);
	assign st_raddr = frdo_pkg::slot_base(tail_q) + frdo_pkg::ADDR_W'(roff_q);

	frdo_ram #(
		.WIDTH(frdo_pkg::DATA_W),
		.DEPTH(frdo_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(q_item.data),
		.re   (is_fe),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	frdo_ram #(
		.WIDTH(frdo_pkg::LEN_W),
		.DEPTH(frdo_pkg::SLOTS)
	) u_len (
		.clk  (clk),
		.we   (commit),
		.waddr(head_q),
		.wdata(cnt_after),
		.re   (is_fe),
		.raddr(tail_q),
		.rdata(len_rdata)
	);

	assign done = (phase_q == PH_DONE) && (!ovalid_q || rsp.ready);

	always_comb begin
		res_status = frdo_pkg::STAT_BYTE;
		res_byte   = '0;
		res_flen   = '0;
		res_first  = 1'b0;
		res_fin    = 1'b0;
		adv_tail   = 1'b0;
		roff_clr   = 1'b0;
		roff_inc   = 1'b0;
		if (empty_s1) begin
			res_status = frdo_pkg::STAT_EMPTY;
		end else begin
			res_flen = frdo_pkg::FRAME_LEN_W'(len_rdata);
			if ((roff_q == '0) && (32'(len_rdata) > 32'(maxlen_s1))) begin
				res_status = frdo_pkg::STAT_TOO_LONG;
				adv_tail   = 1'b1;
			end else begin
				res_byte  = st_rdata;
				res_first = (roff_q == '0);
				if ((frdo_pkg::LEN_W'(roff_q) + frdo_pkg::LEN_W'(1)) >= len_rdata) begin
					res_fin  = 1'b1;
					adv_tail = 1'b1;
					roff_clr = 1'b1;
				end else begin
					roff_inc = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ISSUE;
			head_q   <= '0;
			tail_q   <= '0;
			wcnt_q   <= '0;
			wover_q  <= 1'b0;
			roff_q   <= '0;
			drops_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (is_wr) begin
				if (q_item.last) begin
					wcnt_q  <= '0;
					wover_q <= 1'b0;
				end else if (room) begin
					wcnt_q <= cnt_after;
				end else begin
					wover_q <= 1'b1;
				end
				if (commit) begin
					head_q <= head_nxt;
					if (ring_full) begin
						tail_q  <= frdo_pkg::next_slot(tail_q);
						drops_q <= drops_q + frdo_pkg::DROP_W'(1);
						roff_q  <= '0;
					end
				end
			end
			unique case (phase_q)
				PH_ISSUE: begin
					if (is_fe) begin
						phase_q <= PH_DONE;
					end
				end
				PH_DONE: begin
					if (done) begin
						phase_q <= PH_ISSUE;
					end
				end
				default: begin
					phase_q <= PH_ISSUE;
				end
			endcase
			if (done) begin
				ovalid_q <= 1'b1;
				if (adv_tail) begin
					tail_q <= frdo_pkg::next_slot(tail_q);
				end
				if (roff_clr) begin
					roff_q <= '0;
				end else if (roff_inc) begin
					roff_q <= roff_q + frdo_pkg::OFF_W'(1);
				end
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_fe) begin
			empty_s1  <= (tail_q == head_q);
			maxlen_s1 <= q_item.max_len;
		end
		if (done) begin
			status_q <= res_status;
			byte_q   <= res_byte;
			flen_q   <= res_flen;
			first_q  <= res_first;
			fin_q    <= res_fin;
			dropc_q  <= drops_q;
		end
	end

	assign rsp.valid      = ovalid_q;
	assign rsp.status     = status_q;
	assign rsp.byte_out   = byte_q;
	assign rsp.frame_len  = flen_q;
	assign rsp.first      = first_q;
	assign rsp.final_res  = fin_q;
	assign rsp.drop_count = dropc_q;
endmodule
`default_nettype wire

/* src/frame_ring_drop_oldest_top.sv */
// Frame ring with drop-oldest: queue front end feeding the ring executor.
// A fetch result passes the registered store and length reads, then the response
// register, and waits while rsp.ready is low. Writes are taken one per cycle while
// no fetch is pending; a fetch holds off the next request word until it is done.
// Reset clears pointers, counters and the queue; the memories are not cleared.
// Depends on frdo_pkg, frdo_req_if, frdo_rsp_if, frdo_front and frdo_back.
`default_nettype none
module frame_ring_drop_oldest_top (
	input wire logic clk,
	input wire logic arst_n,
	frdo_req_if.sink   req,
	frdo_rsp_if.source rsp
);
	frdo_pkg::q_entry_t q_item;
	logic               q_valid;
	logic               q_pop;

	frdo_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_item (q_item),
		.q_valid(q_valid),
		.q_pop  (q_pop)
	);

	frdo_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_item (q_item),
		.q_valid(q_valid),
		.q_pop  (q_pop),
		.rsp    (rsp)
	);
endmodule
`default_nettype wire
